>>> hw/rtl/vtc_pkg.sv
// Shared constants, types and the 16-color palette of the terminal cell engine.
// No dependencies; vtc_engine and the top level import this package.
package vtc_pkg;

    // Geometry of the cell store and parameter buffer
    localparam int MAX_COLUMNS = 128;
    localparam int MAX_ROWS    = 64;
    localparam int PARAM_SLOTS = 8;
    localparam int CW          = $clog2(MAX_COLUMNS);
    localparam int RW          = $clog2(MAX_ROWS);
    localparam int AW          = CW + RW;
    localparam int CELLS       = MAX_ROWS * MAX_COLUMNS;
    localparam int SW          = $clog2(PARAM_SLOTS);
    localparam int CELL_W      = 56;

    // Byte codes
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_SAVE  = 8'h37;
    localparam logic [7:0] CH_REST  = 8'h38;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_QUES  = 8'h3F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] FIN_LO   = 8'h40;
    localparam logic [7:0] FIN_HI   = 8'h7E;
    localparam logic [7:0] FIN_CUU  = 8'h41;
    localparam logic [7:0] FIN_CUD  = 8'h42;
    localparam logic [7:0] FIN_CUF  = 8'h43;
    localparam logic [7:0] FIN_CUB  = 8'h44;
    localparam logic [7:0] FIN_CHA  = 8'h47;
    localparam logic [7:0] FIN_CUP  = 8'h48;
    localparam logic [7:0] FIN_HVP  = 8'h66;
    localparam logic [7:0] FIN_VPA  = 8'h64;
    localparam logic [7:0] FIN_SCP  = 8'h73;
    localparam logic [7:0] FIN_RCP  = 8'h75;
    localparam logic [7:0] FIN_ED   = 8'h4A;
    localparam logic [7:0] FIN_EL   = 8'h4B;
    localparam logic [7:0] FIN_SGR  = 8'h6D;
    localparam logic [7:0] FIN_SET  = 8'h68;
    localparam logic [7:0] FIN_RST  = 8'h6C;

    localparam logic [23:0] RGB_WHITE   = 24'hFFFFFF;
    localparam logic [23:0] RGB_BLACK   = 24'h000000;
    localparam logic [15:0] PARAM_MAX   = 16'hFFFF;
    localparam logic [15:0] PRIV_CURSOR = 16'd25;
    localparam logic [CW:0] COLS_RESET  = (CW + 1)'(80);
    localparam logic [RW:0] ROWS_RESET  = (RW + 1)'(25);

    // Configuration register indexes
    localparam logic CFG_COLUMNS = 1'b0;
    localparam logic CFG_ROWS    = 1'b1;

    typedef struct packed {
        logic [7:0]  ch;
        logic [23:0] fg;
        logic [23:0] bg;
    } t_cell;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
        logic [5:0] read_row;
        logic [6:0] read_column;
    } t_item;

    typedef struct packed {
        logic [7:0]  cell_char;
        logic [23:0] cell_foreground;
        logic [23:0] cell_background;
        logic [7:0]  cursor_column;
        logic [5:0]  cursor_row;
        logic        cursor_shown;
        logic        did_scroll;
        logic        did_clear;
    } t_result;

    typedef struct packed {
        logic          we;
        logic [AW-1:0] waddr;
        t_cell         wdata;
        logic          re;
        logic [AW-1:0] raddr;
    } t_mem_req;

    function automatic logic [23:0] palette(input logic [3:0] idx);
        logic [23:0] rgb;
        unique case (idx)
            4'd0:    rgb = 24'h000000;
            4'd1:    rgb = 24'h800000;
            4'd2:    rgb = 24'h008000;
            4'd3:    rgb = 24'h808000;
            4'd4:    rgb = 24'h000080;
            4'd5:    rgb = 24'h800080;
            4'd6:    rgb = 24'h008080;
            4'd7:    rgb = 24'hC0C0C0;
            4'd8:    rgb = 24'h808080;
            4'd9:    rgb = 24'hFF0000;
            4'd10:   rgb = 24'h00FF00;
            4'd11:   rgb = 24'hFFFF00;
            4'd12:   rgb = 24'h0000FF;
            4'd13:   rgb = 24'hFF00FF;
            4'd14:   rgb = 24'h00FFFF;
            default: rgb = 24'hFFFFFF;
        endcase
        return rgb;
    endfunction

endpackage

>>> hw/rtl/vtc_in_if.sv
// Input item channel of the terminal cell engine: valid/ready plus item fields.
// No dependencies.
interface vtc_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] data_byte;
    logic [5:0] read_row;
    logic [6:0] read_column;

    modport source (output valid, command, data_byte, read_row, read_column, input ready);
    modport sink   (input valid, command, data_byte, read_row, read_column, output ready);
endinterface

>>> hw/rtl/vtc_out_if.sv
// Result channel of the terminal cell engine: valid/ready plus result fields.
// No dependencies.
interface vtc_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  cell_char;
    logic [23:0] cell_foreground;
    logic [23:0] cell_background;
    logic [7:0]  cursor_column;
    logic [5:0]  cursor_row;
    logic        cursor_shown;
    logic        did_scroll;
    logic        did_clear;

    modport source (output valid, cell_char, cell_foreground, cell_background, cursor_column,
                    cursor_row, cursor_shown, did_scroll, did_clear, input ready);
    modport sink   (input valid, cell_char, cell_foreground, cell_background, cursor_column,
                    cursor_row, cursor_shown, did_scroll, did_clear, output ready);
endinterface

>>> hw/rtl/vtc_cfg_if.sv
// Configuration write channel: valid/ready, register index and write data.
// No dependencies.
interface vtc_cfg_if;
    logic       valid;
    logic       ready;
    logic       index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/vtc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module vtc_ram #(
    parameter int WIDTH = 56,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds data between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> hw/rtl/vtc_engine.sv
// Parser, cursor state and cell store sequencer of the terminal cell engine.
// Depends on vtc_pkg; drives the cell store RAM through a t_mem_req bundle.
module vtc_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [7:0]        i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  vtc_pkg::t_item    i_item,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output vtc_pkg::t_result  o_res,
    output vtc_pkg::t_mem_req o_mem,
    input  vtc_pkg::t_cell    i_mem_rdata
);
    import vtc_pkg::*;

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SCR_RD = 3'd2;
    localparam logic [2:0] S_SCR_WR = 3'd3;
    localparam logic [2:0] S_FILL   = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_ESC    = 2'd1;
    localparam logic [1:0] MODE_CSI    = 2'd2;

    localparam logic [1:0] GO_DONE   = 2'd0;
    localparam logic [1:0] GO_SCROLL = 2'd1;
    localparam logic [1:0] GO_FILL   = 2'd2;

    logic [2:0]    r_state;
    logic [CW:0]   r_cols, r_col, r_scol;
    logic [RW:0]   r_rows;
    logic [RW-1:0] r_row, r_srow;
    logic [1:0]    r_mode;
    logic [15:0]   r_pv [PARAM_SLOTS];
    logic [SW:0]   r_cnt;
    logic          r_priv, r_vis, r_scroll, r_clear, r_isread, r_pend;
    logic [23:0]   r_fg, r_bg;
    logic [AW-1:0] r_paddr, r_init;
    logic [7:0]    r_pchar;
    logic [RW-1:0] r_fr, r_flast;
    logic [CW:0]   r_fc, r_ffrom, r_fto;

    logic [CW:0]   n_col, n_scol, n_ffrom, n_fto;
    logic [RW-1:0] n_row, n_srow, n_fr, n_flast;
    logic [1:0]    n_mode, n_go;
    logic [15:0]   n_pv [PARAM_SLOTS];
    logic [SW:0]   n_cnt;
    logic          n_priv, n_vis, n_pend, n_clear;
    logic [23:0]   n_fg, n_bg;
    logic [AW-1:0] n_paddr;
    logic [7:0]    n_pchar;

    logic [7:0]    b;
    logic          do_put, row_inc_ok, is_final;
    logic [RW-1:0] rmax;
    logic [CW:0]   cmax;
    logic [SW:0]   cnt1;
    logic [15:0]   p0, p1, p0d, p1d;
    logic [19:0]   digit_acc;
    logic [CW+1:0] tab_next;
    logic [CW:0]   wrap_col;
    logic [RW-1:0] wrap_row;
    logic [16:0]   sum17;
    logic [CW:0]   cfg_cols;
    logic [RW:0]   cfg_rows;
    logic [RW:0]   fr_p1;

    assign b          = i_item.data_byte;
    assign rmax       = RW'(r_rows - 1'b1);
    assign cmax       = r_cols - 1'b1;
    assign row_inc_ok = ((RW + 1)'(r_row) + 1'b1) < r_rows;
    assign cnt1       = (r_cnt < (SW + 1)'(PARAM_SLOTS)) ? r_cnt + 1'b1 : r_cnt;
    assign p0         = r_pv[0];
    assign p1         = (cnt1 > (SW + 1)'(1)) ? r_pv[1] : 16'd0;
    assign p0d        = (p0 == 16'd0) ? 16'd1 : p0;
    assign p1d        = (p1 == 16'd0) ? 16'd1 : p1;
    assign digit_acc  = {r_pv[r_cnt[SW-1:0]], 3'b000} + {3'b000, r_pv[r_cnt[SW-1:0]], 1'b0}
                        + 20'(b - CH_ZERO);
    assign tab_next   = ((CW + 2)'(r_col) + (CW + 2)'(8)) & ~(CW + 2)'(7);
    assign is_final   = (b >= FIN_LO) && (b <= FIN_HI);
    assign fr_p1      = (RW + 1)'(r_fr) + 1'b1;

    // Compute the state after one fed byte
    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_scol  = r_scol;
        n_srow  = r_srow;
        n_mode  = r_mode;
        n_pv    = r_pv;
        n_cnt   = r_cnt;
        n_priv  = r_priv;
        n_vis   = r_vis;
        n_fg    = r_fg;
        n_bg    = r_bg;
        n_pend  = 1'b0;
        n_paddr = {r_row, r_col[CW-1:0]};
        n_pchar = b;
        n_go    = GO_DONE;
        n_fr    = r_row;
        n_flast = r_row;
        n_ffrom = '0;
        n_fto   = r_cols;
        n_clear = 1'b0;
        do_put  = 1'b0;
        wrap_col = r_col;
        wrap_row = r_row;
        sum17    = '0;

        // Parser
        priority case (r_mode)
            MODE_ESC: begin
                n_mode = MODE_NORMAL;
                if (b == CH_LBRK) begin
                    n_mode = MODE_CSI;
                    n_cnt  = '0;
                    n_priv = 1'b0;
                    for (int i = 0; i < PARAM_SLOTS; i++) begin
                        n_pv[i] = '0;
                    end
                end else if (b == CH_SAVE) begin
                    n_scol = r_col;
                    n_srow = r_row;
                end else if (b == CH_REST) begin
                    n_col = r_scol;
                    n_row = r_srow;
                end else begin
                    do_put = 1'b1;
                end
            end
            MODE_CSI: begin
                if (b >= CH_ZERO && b <= CH_NINE) begin
                    if (r_cnt < (SW + 1)'(PARAM_SLOTS)) begin
                        n_pv[r_cnt[SW-1:0]] = (digit_acc > 20'(PARAM_MAX)) ? PARAM_MAX
                                                                            : digit_acc[15:0];
                    end
                end else if (b == CH_SEMI) begin
                    n_cnt = cnt1;
                end else if (b == CH_QUES && r_cnt == '0 && r_pv[0] == 16'd0) begin
                    n_priv = 1'b1;
                end else if (is_final) begin
                    n_cnt  = cnt1;
                    n_mode = MODE_NORMAL;
                    if (r_priv) begin
                        if (b == FIN_SET && p0 == PRIV_CURSOR) begin
                            n_vis = 1'b1;
                        end else if (b == FIN_RST && p0 == PRIV_CURSOR) begin
                            n_vis = 1'b0;
                        end
                    end else begin
                        unique case (b)
                            FIN_CUU: n_row = (p0d >= 16'(r_row)) ? '0 : r_row - RW'(p0d);
                            FIN_CUD: begin
                                sum17 = 17'(r_row) + 17'(p0d);
                                n_row = (sum17 > 17'(rmax)) ? rmax : RW'(sum17);
                            end
                            FIN_CUF: begin
                                sum17 = 17'(r_col) + 17'(p0d);
                                n_col = (sum17 > 17'(cmax)) ? cmax : (CW + 1)'(sum17);
                            end
                            FIN_CUB: n_col = (p0d >= 16'(r_col)) ? '0 : r_col - (CW + 1)'(p0d);
                            FIN_CHA: n_col = ((p0d - 1'b1) > 16'(cmax)) ? cmax
                                                                         : (CW + 1)'(p0d - 1'b1);
                            FIN_VPA: n_row = ((p0d - 1'b1) > 16'(rmax)) ? rmax
                                                                         : RW'(p0d - 1'b1);
                            FIN_CUP, FIN_HVP: begin
                                n_row = ((p0d - 1'b1) > 16'(rmax)) ? rmax : RW'(p0d - 1'b1);
                                n_col = ((p1d - 1'b1) > 16'(cmax)) ? cmax
                                                                    : (CW + 1)'(p1d - 1'b1);
                            end
                            FIN_SCP: begin
                                n_scol = r_col;
                                n_srow = r_row;
                            end
                            FIN_RCP: begin
                                n_col = r_scol;
                                n_row = r_srow;
                            end
                            FIN_ED: begin
                                if (p0 == 16'd2) begin
                                    n_go    = GO_FILL;
                                    n_fr    = '0;
                                    n_flast = rmax;
                                    n_row   = '0;
                                    n_col   = '0;
                                    n_clear = 1'b1;
                                end
                            end
                            FIN_EL: begin
                                n_go = GO_FILL;
                                if (p0 == 16'd0) begin
                                    n_ffrom = r_col;
                                end else if (p0 == 16'd1) begin
                                    n_fto = ((CW + 2)'(r_col) + 1'b1 > (CW + 2)'(r_cols))
                                            ? r_cols : r_col + 1'b1;
                                end
                            end
                            FIN_SGR: begin
                                for (int i = 0; i < PARAM_SLOTS; i++) begin
                                    if ((SW + 1)'(i) < cnt1) begin
                                        if (r_pv[i] == 16'd0) begin
                                            n_fg = RGB_WHITE;
                                            n_bg = RGB_BLACK;
                                        end else if (r_pv[i] >= 16'd30 && r_pv[i] <= 16'd37) begin
                                            n_fg = palette(4'(r_pv[i] - 16'd30));
                                        end else if (r_pv[i] >= 16'd40 && r_pv[i] <= 16'd47) begin
                                            n_bg = palette(4'(r_pv[i] - 16'd40));
                                        end else if (r_pv[i] >= 16'd90 && r_pv[i] <= 16'd97) begin
                                            n_fg = palette(4'(r_pv[i] - 16'd82));
                                        end else if (r_pv[i] >= 16'd100
                                                     && r_pv[i] <= 16'd107) begin
                                            n_bg = palette(4'(r_pv[i] - 16'd92));
                                        end
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            default: begin
                if (b == CH_ESC) begin
                    n_mode = MODE_ESC;
                end else begin
                    do_put = 1'b1;
                end
            end
        endcase

        // Normal byte handling
        if (do_put) begin
            if (b == CH_LF) begin
                n_col = '0;
                if (row_inc_ok) begin
                    n_row = r_row + 1'b1;
                end else begin
                    n_go = GO_SCROLL;
                end
            end else if (b == CH_CR) begin
                n_col = '0;
            end else if (b == CH_BS) begin
                if (r_col != '0) begin
                    n_col   = r_col - 1'b1;
                    n_pend  = 1'b1;
                    n_paddr = {r_row, CW'(r_col - 1'b1)};
                    n_pchar = CH_SPACE;
                end
            end else if (b == CH_TAB) begin
                if (tab_next >= (CW + 2)'(r_cols)) begin
                    n_col = '0;
                    if (row_inc_ok) begin
                        n_row = r_row + 1'b1;
                    end
                end else begin
                    n_col = (CW + 1)'(tab_next);
                end
            end else begin
                if (r_col >= r_cols) begin
                    wrap_col = '0;
                    if (row_inc_ok) begin
                        wrap_row = r_row + 1'b1;
                    end else begin
                        n_go = GO_SCROLL;
                    end
                end
                n_row   = wrap_row;
                n_col   = wrap_col + 1'b1;
                n_pend  = 1'b1;
                n_paddr = {wrap_row, wrap_col[CW-1:0]};
            end
        end
    end

    // New screen size on a configuration write
    always_comb begin
        cfg_cols = r_cols;
        cfg_rows = r_rows;
        if (i_cfg_idx == CFG_COLUMNS) begin
            if (i_cfg_data[CW:0] == '0) begin
                cfg_cols = (CW + 1)'(1);
            end else if (i_cfg_data[CW:0] > (CW + 1)'(MAX_COLUMNS)) begin
                cfg_cols = (CW + 1)'(MAX_COLUMNS);
            end else begin
                cfg_cols = i_cfg_data[CW:0];
            end
        end else begin
            if (i_cfg_data[RW:0] == '0) begin
                cfg_rows = (RW + 1)'(1);
            end else if (i_cfg_data[RW:0] > (RW + 1)'(MAX_ROWS)) begin
                cfg_rows = (RW + 1)'(MAX_ROWS);
            end else begin
                cfg_rows = i_cfg_data[RW:0];
            end
        end
    end

    // Sequencer and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_init   <= '0;
            r_cols   <= COLS_RESET;
            r_rows   <= ROWS_RESET;
            r_col    <= '0;
            r_row    <= '0;
            r_scol   <= '0;
            r_srow   <= '0;
            r_mode   <= MODE_NORMAL;
            r_cnt    <= '0;
            r_priv   <= 1'b0;
            r_vis    <= 1'b1;
            r_fg     <= RGB_WHITE;
            r_bg     <= RGB_BLACK;
            r_scroll <= 1'b0;
            r_clear  <= 1'b0;
            r_isread <= 1'b0;
            r_pend   <= 1'b0;
            for (int i = 0; i < PARAM_SLOTS; i++) begin
                r_pv[i] <= '0;
            end
        end else begin
            unique case (r_state)
                S_INIT: begin
                    r_init <= r_init + 1'b1;
                    if (&r_init) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_isread <= i_item.command;
                        r_scroll <= 1'b0;
                        r_clear  <= 1'b0;
                        r_pend   <= 1'b0;
                        r_state  <= S_DONE;
                        if (!i_item.command) begin
                            r_col   <= n_col;
                            r_row   <= n_row;
                            r_scol  <= n_scol;
                            r_srow  <= n_srow;
                            r_mode  <= n_mode;
                            r_pv    <= n_pv;
                            r_cnt   <= n_cnt;
                            r_priv  <= n_priv;
                            r_vis   <= n_vis;
                            r_fg    <= n_fg;
                            r_bg    <= n_bg;
                            r_pend  <= n_pend;
                            r_paddr <= n_paddr;
                            r_pchar <= n_pchar;
                            r_clear <= n_clear;
                            unique case (n_go)
                                GO_FILL: begin
                                    r_fr    <= n_fr;
                                    r_flast <= n_flast;
                                    r_fc    <= n_ffrom;
                                    r_ffrom <= n_ffrom;
                                    r_fto   <= n_fto;
                                    r_state <= S_FILL;
                                end
                                GO_SCROLL: begin
                                    r_scroll <= 1'b1;
                                    r_fc     <= '0;
                                    if (r_rows == (RW + 1)'(1)) begin
                                        r_fr    <= rmax;
                                        r_flast <= rmax;
                                        r_ffrom <= '0;
                                        r_fto   <= r_cols;
                                        r_state <= S_FILL;
                                    end else begin
                                        r_fr    <= '0;
                                        r_state <= S_SCR_RD;
                                    end
                                end
                                default: r_state <= S_DONE;
                            endcase
                        end
                    end
                end
                S_SCR_RD: r_state <= S_SCR_WR;
                S_SCR_WR: begin
                    r_state <= S_SCR_RD;
                    if (r_fc + 1'b1 == r_cols) begin
                        r_fc <= '0;
                        if (fr_p1 == (RW + 1)'(rmax)) begin
                            r_fr    <= rmax;
                            r_flast <= rmax;
                            r_ffrom <= '0;
                            r_fto   <= r_cols;
                            r_state <= S_FILL;
                        end else begin
                            r_fr <= r_fr + 1'b1;
                        end
                    end else begin
                        r_fc <= r_fc + 1'b1;
                    end
                end
                S_FILL: begin
                    if (r_fc < r_fto) begin
                        r_fc <= r_fc + 1'b1;
                    end else if (r_fr == r_flast) begin
                        r_state <= S_DONE;
                    end else begin
                        r_fr <= r_fr + 1'b1;
                        r_fc <= r_ffrom;
                    end
                end
                S_DONE: begin
                    r_pend <= 1'b0;
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            // Resize and pull both cursors into the new screen
            if (i_cfg_we) begin
                r_cols <= cfg_cols;
                r_rows <= cfg_rows;
                if ((RW + 1)'(r_row) >= cfg_rows) begin
                    r_row <= RW'(cfg_rows - 1'b1);
                end
                if (r_col > cfg_cols) begin
                    r_col <= cfg_cols;
                end
                if ((RW + 1)'(r_srow) >= cfg_rows) begin
                    r_srow <= RW'(cfg_rows - 1'b1);
                end
                if (r_scol > cfg_cols) begin
                    r_scol <= cfg_cols;
                end
            end
        end
    end

    // Cell store requests
    always_comb begin
        o_mem       = '0;
        o_mem.wdata = '{ch: CH_SPACE, fg: r_fg, bg: r_bg};
        unique case (r_state)
            S_INIT: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_init;
                o_mem.wdata = '{ch: CH_SPACE, fg: RGB_WHITE, bg: RGB_BLACK};
            end
            S_IDLE: begin
                o_mem.re    = i_in_valid && i_item.command;
                o_mem.raddr = {i_item.read_row, i_item.read_column};
            end
            S_SCR_RD: begin
                o_mem.re    = 1'b1;
                o_mem.raddr = {RW'(fr_p1), r_fc[CW-1:0]};
            end
            S_SCR_WR: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = {r_fr, r_fc[CW-1:0]};
                o_mem.wdata = i_mem_rdata;
            end
            S_FILL: begin
                o_mem.we    = r_fc < r_fto;
                o_mem.waddr = {r_fr, r_fc[CW-1:0]};
            end
            S_DONE: begin
                o_mem.we    = r_pend;
                o_mem.waddr = r_paddr;
                o_mem.wdata = '{ch: r_pchar, fg: r_fg, bg: r_bg};
            end
            default: ;
        endcase
    end

    // Result of the finished item
    assign o_in_ready              = (r_state == S_IDLE);
    assign o_res_valid             = (r_state == S_DONE);
    assign o_res.cell_char         = r_isread ? i_mem_rdata.ch : 8'd0;
    assign o_res.cell_foreground   = r_isread ? i_mem_rdata.fg : 24'd0;
    assign o_res.cell_background   = r_isread ? i_mem_rdata.bg : 24'd0;
    assign o_res.cursor_column     = 8'(r_col);
    assign o_res.cursor_row        = 6'(r_row);
    assign o_res.cursor_shown      = r_vis;
    assign o_res.did_scroll        = r_scroll;
    assign o_res.did_clear         = r_clear;
endmodule

>>> hw/rtl/vt100_terminal_cell_engine_core.sv
// Top level of the terminal cell engine: cell store RAM, engine and output register.
// Depends on vtc_pkg, the channel interfaces, vtc_ram and vtc_engine.
//
//   channel | dir | transfer when       | carries
//   i_in    | in  | valid && ready      | command, data_byte, read_row, read_column
//   o_out   | out | valid && ready      | cell fields, cursor, shown, scroll, clear
//   i_cfg   | in  | valid (ready tied)  | index (0 columns, 1 rows), data
//
// A read or a byte that only touches one cell needs at most one cell store access; one
// port serves the rest: a scroll moves rows 1 to rows-1 up a row, cell by cell, then
// blanks the last row; erase display blanks all rows, erase line part of one row.
// After reset a clearing pass fills all 8192 cells of the store; no item is taken then.
// The output register lets the next item start while a result waits to be taken.
module vt100_terminal_cell_engine_core (
    input  logic i_clk,
    input  logic i_rst_n,
    vtc_in_if.sink   i_in,
    vtc_out_if.source o_out,
    vtc_cfg_if.sink  i_cfg
);
    import vtc_pkg::*;

    t_item    item;
    t_result  res;
    t_mem_req mem;
    t_cell    rdata;
    logic     res_valid, res_ready;
    logic     r_out_valid;
    t_result  r_out;

    assign item = '{command: i_in.command, data_byte: i_in.data_byte,
                    read_row: i_in.read_row, read_column: i_in.read_column};
    assign i_cfg.ready = 1'b1;

    vtc_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_store (
        .i_clk   (i_clk),
        .i_we    (mem.we),
        .i_waddr (mem.waddr),
        .i_wdata (mem.wdata),
        .i_re    (mem.re),
        .i_raddr (mem.raddr),
        .o_rdata (rdata)
    );

    vtc_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_idx   (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_item      (item),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_mem       (mem),
        .i_mem_rdata (rdata)
    );

    // Output register: load a finished result, drop it on transfer
    assign res_ready = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.cell_char       = r_out.cell_char;
    assign o_out.cell_foreground = r_out.cell_foreground;
    assign o_out.cell_background = r_out.cell_background;
    assign o_out.cursor_column   = r_out.cursor_column;
    assign o_out.cursor_row      = r_out.cursor_row;
    assign o_out.cursor_shown    = r_out.cursor_shown;
    assign o_out.did_scroll      = r_out.did_scroll;
    assign o_out.did_clear       = r_out.did_clear;
endmodule
